[rtl/tilt_pkg.sv]
// ----------------------------------------------------------------------------
// tilt_pkg
// Shared types, widths and the arc-cosine table of the accelerometer tilt
// block.
// ----------------------------------------------------------------------------
package tilt_pkg;

  // Averaging window and sensor scale
  localparam int unsigned Window       = 20;
  localparam int unsigned CountsPerG   = 17694;
  localparam int unsigned CosOne       = 1024;
  localparam int unsigned AngleMax     = 46080;
  localparam int unsigned AngleQuarter = 23040;

  // Running sum per axis, and its magnitude
  localparam int unsigned SumW = $clog2(Window * 32768) + 1;

  // Rounded cosine: q = (2048*mag + Den) / Div2, taken by reciprocal
  localparam int unsigned       Den    = Window * CountsPerG;
  localparam int unsigned       Div2   = 2 * Den;
  localparam longint unsigned   NumMax = longint'(Window) * 2048 * 32768 + longint'(Den);
  localparam int unsigned       NumW   = $clog2(NumMax + 1);
  localparam longint unsigned   Recip  = (longint'(1) << NumW) / Div2;
  localparam int unsigned       RecipW = $clog2(Recip + 1);
  localparam int unsigned       ProdW  = NumW + RecipW;
  localparam int unsigned       QW     = 11;

  // Arc-cosine series constants
  localparam logic [63:0] HalfSteps = 64'd92160;
  localparam logic [63:0] PiQ61     = 64'h6487ED5110B4611A;
  localparam logic [63:0] OneQ61    = 64'h2000000000000000;

  typedef struct packed {
    logic signed [15:0] x_sample;
    logic signed [15:0] y_sample;
    logic signed [15:0] z_sample;
  } tilt_in_t;

  typedef struct packed {
    logic [15:0] x_angle;
    logic [15:0] y_angle;
    logic [15:0] z_angle;
  } tilt_out_t;

  typedef logic [15:0] acos_tab_t [CosOne+1];

  // (a * b) >> 61 on Q61 operands
  function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    al  = {32'd0, a[31:0]};
    ah  = {32'd0, a[63:32]};
    bl  = {32'd0, b[31:0]};
    bh  = {32'd0, b[63:32]};
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = {32'd0, ll[63:32]} + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
    lo  = {mid[31:0], ll[31:0]};
    hi  = hh + {32'd0, lh[63:32]} + {32'd0, hl[63:32]} + {32'd0, mid[63:32]};
    return (hi << 3) | (lo >> 61);
  endfunction

  // Divide by (2j-1)*2j for series term j
  function automatic logic [63:0] div_pair(input logic [63:0] v, input logic [4:0] j);
    logic [63:0] r;
    case (j)
      5'd1:    r = v / 2;
      5'd2:    r = v / 12;
      5'd3:    r = v / 30;
      5'd4:    r = v / 56;
      5'd5:    r = v / 90;
      5'd6:    r = v / 132;
      5'd7:    r = v / 182;
      5'd8:    r = v / 240;
      5'd9:    r = v / 306;
      5'd10:   r = v / 380;
      5'd11:   r = v / 462;
      5'd12:   r = v / 552;
      5'd13:   r = v / 650;
      5'd14:   r = v / 756;
      5'd15:   r = v / 870;
      5'd16:   r = v / 992;
      5'd17:   r = v / 1122;
      5'd18:   r = v / 1260;
      5'd19:   r = v / 1406;
      5'd20:   r = v / 1560;
      default: r = v;
    endcase
    return r;
  endfunction

  // True when cos(k*pi/92160) < x, x in Q61
  function automatic logic cos_below(input logic [63:0] k, input logic [63:0] x);
    logic [63:0] q, r, t, t2, term, acc, diff;
    q    = PiQ61 / HalfSteps;
    r    = PiQ61 % HalfSteps;
    t    = k * q + (k * r) / HalfSteps;
    t2   = mul_q61(t, t);
    term = OneQ61;
    acc  = OneQ61;
    for (int j = 1; j <= 20; j++) begin
      term = div_pair(mul_q61(term, t2), 5'(j));
      if (j % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    diff = acc - x;
    return diff[63];
  endfunction

  // Angle code for a cosine code 0 .. 1024, by bisection
  function automatic logic [15:0] angle_nonneg(input logic [10:0] c);
    logic [63:0] x;
    logic [15:0] lo, hi, mid;
    x  = 64'(c) << 51;
    lo = 16'd0;
    hi = 16'(AngleQuarter);
    for (int s = 0; s < 16; s++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (cos_below((64'(mid) << 1) | 64'd1, x)) begin
          hi = mid;
        end else begin
          lo = mid + 16'd1;
        end
      end
    end
    return lo;
  endfunction

  function automatic acos_tab_t build_acos_tab();
    acos_tab_t tab;
    for (int c = 0; c <= int'(CosOne); c++) begin
      tab[c] = angle_nonneg(11'(c));
    end
    return tab;
  endfunction

  localparam acos_tab_t AcosTab = build_acos_tab();

endpackage

[rtl/tilt_cell.sv]
// ----------------------------------------------------------------------------
// tilt_cell
// One slot of the sample history: holds a 3-axis sample and passes it to the
// next cell on every accepted transaction.
// ----------------------------------------------------------------------------
module tilt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  tilt_pkg::tilt_in_t sample_i,
  output tilt_pkg::tilt_in_t sample_o
);

  tilt_pkg::tilt_in_t sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

[rtl/tilt_lane.sv]
// ----------------------------------------------------------------------------
// tilt_lane
// Per-axis datapath: window sum to rounded cosine to angle in Q8.8.
// Four register stages; advances when adv_i is high.
// ----------------------------------------------------------------------------
module tilt_lane (
  input  logic                              clk_i,
  input  logic                              adv_i,
  input  logic signed [tilt_pkg::SumW-1:0]  sum_i,
  output logic        [15:0]                angle_o
);

  localparam int unsigned SumW  = tilt_pkg::SumW;
  localparam int unsigned NumW  = tilt_pkg::NumW;
  localparam int unsigned ProdW = tilt_pkg::ProdW;
  localparam int unsigned QW    = tilt_pkg::QW;

  logic [SumW-1:0]  mag;
  logic [NumW-1:0]  num;
  logic [ProdW-1:0] prod_d;

  logic             neg2_q, neg3_q, neg4_q;
  logic [NumW-1:0]  num_q;
  logic [ProdW-1:0] prod_q;

  logic [QW-1:0]    q_est, q_fix, cos_d;
  logic [NumW-1:0]  rem;
  logic [QW-1:0]    cos_q;
  logic [15:0]      raw_q;
  logic [15:0]      angle_q;

  // Stage 2: magnitude, rounding numerator and reciprocal product
  always_comb begin
    mag    = sum_i[SumW-1] ? SumW'(-sum_i) : SumW'(sum_i);
    num    = (NumW'(mag) << 11) + NumW'(tilt_pkg::Den);
    prod_d = ProdW'(num) * ProdW'(tilt_pkg::Recip);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      neg2_q <= sum_i[SumW-1];
      num_q  <= num;
      prod_q <= prod_d;
    end
  end

  // Stage 3: estimate is the quotient or one below; correct and clamp
  always_comb begin
    q_est = QW'(prod_q >> NumW);
    rem   = num_q - NumW'(q_est) * NumW'(tilt_pkg::Div2);
    q_fix = (rem >= NumW'(tilt_pkg::Div2)) ? q_est + QW'(1) : q_est;
    cos_d = (q_fix > QW'(tilt_pkg::CosOne)) ? QW'(tilt_pkg::CosOne) : q_fix;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      neg3_q <= neg2_q;
      cos_q  <= cos_d;
    end
  end

  // Stage 4: arc-cosine lookup
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      neg4_q <= neg3_q;
      raw_q  <= tilt_pkg::AcosTab[cos_q];
    end
  end

  // Stage 5: reflect for negative cosines
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      angle_q <= neg4_q ? 16'(tilt_pkg::AngleMax) - raw_q : raw_q;
    end
  end

  assign angle_o = angle_q;

endmodule

[rtl/accel_moving_average_tilt.sv]
// ----------------------------------------------------------------------------
// accel_moving_average_tilt
// Boxcar average of the last 20 accelerometer samples per axis, returned as
// the tilt angle to each axis in unsigned Q8.8 degrees.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one raw 3-axis sample per
//   transaction; output channel out_valid_o/out_ready_i returns one set of
//   three angles per input sample, in order.
//   An accepted sample goes into the running sums, then the lanes. Throughput is
//   one sample per cycle: the history is a chain of 20 cells that shifts on
//   each accepted sample, and a running sum per axis is updated in the same
//   cycle; the divide, lookup and reflect steps run in a 4-stage pipeline.
//   When the receiver stalls, the whole pipeline holds and in_ready_o drops
//   until the held result is taken; no result is lost or repeated.
//   Reset clears the history and the sums, so the first 19 results average
//   in zeros. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module accel_moving_average_tilt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tilt_pkg::tilt_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tilt_pkg::tilt_out_t out_data_o
);

  localparam int unsigned Window = tilt_pkg::Window;
  localparam int unsigned SumW   = tilt_pkg::SumW;

  logic                   adv;
  logic                   accept;
  logic [4:0]             vld_q;

  tilt_pkg::tilt_in_t     chain [Window+1];
  tilt_pkg::tilt_in_t     oldest;

  logic signed [SumW-1:0] x_sum_q, y_sum_q, z_sum_q;
  logic signed [SumW-1:0] x_sum_d, y_sum_d, z_sum_d;

  // Advance everything unless a result waits at the output
  assign adv        = !vld_q[4] || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  assign chain[0] = in_data_i;

  for (genvar i = 0; i < Window; i++) begin : g_cell
    tilt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (accept),
      .sample_i (chain[i]),
      .sample_o (chain[i+1])
    );
  end

  assign oldest = chain[Window];

  // Add the new sample, drop the one leaving the window
  always_comb begin
    x_sum_d = x_sum_q + SumW'(in_data_i.x_sample) - SumW'(oldest.x_sample);
    y_sum_d = y_sum_q + SumW'(in_data_i.y_sample) - SumW'(oldest.y_sample);
    z_sum_d = z_sum_q + SumW'(in_data_i.z_sample) - SumW'(oldest.z_sample);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_sum_q <= '0;
      y_sum_q <= '0;
      z_sum_q <= '0;
    end else if (accept) begin
      x_sum_q <= x_sum_d;
      y_sum_q <= y_sum_d;
      z_sum_q <= z_sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  tilt_lane u_lane_x (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .sum_i   (x_sum_q),
    .angle_o (out_data_o.x_angle)
  );

  tilt_lane u_lane_y (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .sum_i   (y_sum_q),
    .angle_o (out_data_o.y_angle)
  );

  tilt_lane u_lane_z (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .sum_i   (z_sum_q),
    .angle_o (out_data_o.z_angle)
  );

  assign out_valid_o = vld_q[4];

endmodule
